### hdl/assert_macros.svh
// Assertion macros used by the checker file of the chunked decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked only outside of reset.
`define HCD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hcd checker: assertion failed");

// Concurrent assertion that is also checked while reset is applied.
`define HCD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hcd checker: assertion failed during reset");

`endif

### hdl/hcd_pkg.sv
// Types, codes and the hex digit decoder for the HTTP chunked body decoder.
`timescale 1ns / 1ps

package hcd_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] event_type;

   localparam mode_type MODE_SIZE    = 2'd0;
   localparam mode_type MODE_DATA    = 2'd1;
   localparam mode_type MODE_END     = 2'd2;
   localparam mode_type MODE_TRAILER = 2'd3;

   localparam event_type EV_PAYLOAD      = 2'd0;
   localparam event_type EV_DONE         = 2'd1;
   localparam event_type EV_DONE_TRAILER = 2'd2;
   localparam event_type EV_ERROR        = 2'd3;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Returns the digit value in the low four bits and a valid flag on top.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      begin
         r = 5'd0;
         if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
         end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
         end
         return r;
      end
   endfunction

endpackage

### hdl/http_chunked_decoder.sv
// Top level of the streaming HTTP chunked transfer decoder.
`timescale 1ns / 1ps

// The decoder takes one byte of a chunked body per request and returns at most
// one response per byte: a payload byte, a completion marker (with or without
// trailers) or a size line error. A request is parsed in one pass of logic
// between the input register and the response register, so a byte can be
// accepted in every cycle while the response side does not stall. An accepted
// request passes the input register and then the response register, from which
// its response drives the response ports. Size lines may carry up to SIZE_BITS
// bits of hex; chunk extensions and trailer contents are skipped.
module http_chunked_decoder
   import hcd_pkg::*;
#(
   parameter int SIZE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte
);

   localparam logic [SIZE_BITS-1:0] SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   event_type            out_event_ff, out_event_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 fire;

   mode_type             mode_ff, mode_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [SIZE_BITS-1:0] size_accum_ff, size_accum_in;
   logic                 hex_done_ff, hex_done_in;
   logic                 hex_seen_ff, hex_seen_in;
   logic [1:0]           line_len_ff, line_len_in;
   logic                 prev_cr_ff, prev_cr_in;
   logic                 line_empty_ff, line_empty_in;

   logic [4:0]           hex;
   logic [SIZE_BITS-1:0] bytes_dec;
   logic                 is_cr, is_lf;

   assign fire      = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = out_event_ff;
   assign rsp_payload_byte = out_byte_ff;

   assign hex   = hex_decode(in_byte_ff);
   assign is_cr = (in_byte_ff == CHAR_CR);
   assign is_lf = (in_byte_ff == CHAR_LF);
   assign bytes_dec = (bytes_left_ff != '0) ? bytes_left_ff - SIZE_ONE : '0;

   always_comb begin
      mode_in       = mode_ff;
      bytes_left_in = bytes_left_ff;
      size_accum_in = size_accum_ff;
      hex_done_in   = hex_done_ff;
      hex_seen_in   = hex_seen_ff;
      line_len_in   = line_len_ff;
      prev_cr_in    = prev_cr_ff;
      line_empty_in = line_empty_ff;
      out_valid_in  = 1'b0;
      out_event_in  = EV_PAYLOAD;
      out_byte_in   = 8'd0;
      case (mode_ff)
         MODE_SIZE: begin
            if (is_lf) begin
               size_accum_in = '0;
               hex_done_in   = 1'b0;
               hex_seen_in   = 1'b0;
               line_len_in   = 2'd0;
               prev_cr_in    = 1'b0;
               line_empty_in = 1'b1;
               if (line_len_ff <= 2'd1) begin
                  if (!(line_len_ff == 2'd1 && prev_cr_ff)) begin
                     out_valid_in = 1'b1;
                     out_event_in = EV_ERROR;
                  end
               end else if (!hex_seen_ff) begin
                  out_valid_in = 1'b1;
                  out_event_in = EV_ERROR;
               end else begin
                  bytes_left_in = size_accum_ff;
                  mode_in       = (size_accum_ff == '0) ? MODE_END : MODE_DATA;
               end
            end else begin
               if (line_len_ff != 2'd3) begin
                  line_len_in = line_len_ff + 2'd1;
               end
               prev_cr_in = is_cr;
               if (!hex_done_ff) begin
                  if (!hex[4]) begin
                     hex_done_in = 1'b1;
                  end else if (size_accum_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                     hex_done_in = 1'b1;
                     hex_seen_in = 1'b0;
                  end else begin
                     size_accum_in = {size_accum_ff[SIZE_BITS-5:0], hex[3:0]};
                     hex_seen_in   = 1'b1;
                  end
               end
            end
         end
         MODE_DATA: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) begin
               mode_in       = MODE_SIZE;
               size_accum_in = '0;
               hex_done_in   = 1'b0;
               hex_seen_in   = 1'b0;
               line_len_in   = 2'd0;
               prev_cr_in    = 1'b0;
               line_empty_in = 1'b1;
            end
            out_valid_in = 1'b1;
            out_event_in = EV_PAYLOAD;
            out_byte_in  = in_byte_ff;
         end
         MODE_END: begin
            if (is_lf && prev_cr_ff) begin
               mode_in       = MODE_SIZE;
               size_accum_in = '0;
               hex_done_in   = 1'b0;
               hex_seen_in   = 1'b0;
               line_len_in   = 2'd0;
               prev_cr_in    = 1'b0;
               line_empty_in = 1'b1;
               out_valid_in  = 1'b1;
               out_event_in  = EV_DONE;
            end else if (is_cr) begin
               prev_cr_in = 1'b1;
            end else begin
               mode_in       = MODE_TRAILER;
               prev_cr_in    = 1'b0;
               line_empty_in = 1'b0;
            end
         end
         default: begin
            if (is_lf) begin
               if (prev_cr_ff && line_empty_ff) begin
                  mode_in       = MODE_SIZE;
                  size_accum_in = '0;
                  hex_done_in   = 1'b0;
                  hex_seen_in   = 1'b0;
                  line_len_in   = 2'd0;
                  prev_cr_in    = 1'b0;
                  line_empty_in = 1'b1;
                  out_valid_in  = 1'b1;
                  out_event_in  = EV_DONE_TRAILER;
               end else begin
                  line_empty_in = 1'b1;
                  prev_cr_in    = 1'b0;
               end
            end else if (is_cr) begin
               if (prev_cr_ff) begin
                  line_empty_in = 1'b0;
               end
               prev_cr_in = 1'b1;
            end else begin
               line_empty_in = 1'b0;
               prev_cr_in    = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= MODE_SIZE;
         bytes_left_ff <= '0;
         size_accum_ff <= '0;
         hex_done_ff   <= 1'b0;
         hex_seen_ff   <= 1'b0;
         line_len_ff   <= 2'd0;
         prev_cr_ff    <= 1'b0;
         line_empty_ff <= 1'b1;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff  <= out_valid_in;
            mode_ff       <= mode_in;
            bytes_left_ff <= bytes_left_in;
            size_accum_ff <= size_accum_in;
            hex_done_ff   <= hex_done_in;
            hex_seen_ff   <= hex_seen_in;
            line_len_ff   <= line_len_in;
            prev_cr_ff    <= prev_cr_in;
            line_empty_ff <= line_empty_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (fire) begin
         out_event_ff <= out_event_in;
         out_byte_ff  <= out_byte_in;
      end
   end

endmodule

### hdl/hcd_checker.sv
// Port-level checker for the chunked decoder and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_res,
   input logic [7:0] rsp_payload_byte
);

   // A stalled response keeps its contents.
   `HCD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res) && $stable(rsp_payload_byte))

   // A stalled request keeps its byte.
   `HCD_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_data_byte))

   // Requests are only held back while a response waits to be taken.
   `HCD_ASSERT(a_req_flow, clock, reset, (!rsp_valid || !rsp_stall) |-> !req_stall)

   // A stalled request means the pending response is still shown next cycle.
   `HCD_ASSERT(a_stall_keeps_rsp, clock, reset, req_stall |=> rsp_valid)

   // Reset empties the response register.
   `HCD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (.*);
